@@ design/hck_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the Hilbert curve key unit.
// No dependencies; imported by hck_level and hilbert_curve_key_unit.
package hck_pkg;

  localparam int LEVEL_COUNT_WIDTH = 5;
  localparam int KEY_WIDTH         = 32;

  localparam logic [LEVEL_COUNT_WIDTH-1:0] LEVEL_COUNT_RESET = 5'd16;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // Red and blue axes; each component is -1, 0 or +1 and the axes stay
  // perpendicular, so exactly one component of each is nonzero.
  typedef struct packed {
    logic signed [1:0] rx;
    logic signed [1:0] ry;
    logic signed [1:0] bx;
    logic signed [1:0] by;
  } hck_axes_t;

  localparam hck_axes_t AXES_INIT = '{rx: 2'sd1, ry: 2'sd0, bx: 2'sd0, by: 2'sd1};

  // Projection of the offset onto an axis is <= 0.
  function automatic logic proj_le0(input logic signed [1:0] ax,
                                    input logic signed [1:0] ay,
                                    input logic x_pos, input logic x_neg,
                                    input logic y_pos, input logic y_neg);
    logic res;
    if (ax > 2'sd0)      res = !x_pos;
    else if (ax < 2'sd0) res = !x_neg;
    else if (ay > 2'sd0) res = !y_pos;
    else                 res = !y_neg;
    return res;
  endfunction

  function automatic logic signed [2:0] ext3(input logic signed [1:0] v);
    return {v[1], v};
  endfunction

endpackage

@@ design/hck_level.sv @@
`timescale 1ns / 1ps
// One subdivision level of the Hilbert key pipeline, with its output register.
// Depends on hck_pkg.
module hck_level #(
  parameter int COORD_WIDTH = 16,
  parameter int MAX_DEPTH   = 16,
  parameter int LEVEL       = 0,
  parameter int W           = COORD_WIDTH + MAX_DEPTH + 1,
  parameter int KW          = 2 * MAX_DEPTH
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic [hck_pkg::LEVEL_COUNT_WIDTH-1:0]     level_count,
  input  logic                                      in_valid,
  input  logic signed [W-1:0]                       in_dx,
  input  logic signed [W-1:0]                       in_dy,
  input  hck_pkg::hck_axes_t                        in_axes,
  input  logic [KW-1:0]                             in_key,
  output logic                                      out_valid,
  output logic signed [W-1:0]                       out_dx,
  output logic signed [W-1:0]                       out_dy,
  output hck_pkg::hck_axes_t                        out_axes,
  output logic [KW-1:0]                             out_key
);
  import hck_pkg::*;

  localparam int HSHIFT = COORD_WIDTH - 2 - LEVEL + MAX_DEPTH;
  localparam int KSHIFT = 2 * (MAX_DEPTH - 1 - LEVEL);
  localparam logic signed [W-1:0] STEP = {{(W-1){1'b0}}, 1'b1} << HSHIFT;
  localparam logic [LEVEL_COUNT_WIDTH:0] LEVEL_IDX = (LEVEL_COUNT_WIDTH+1)'(LEVEL);

  logic              active;
  logic              dx_pos, dx_neg, dy_pos, dy_neg;
  logic              r_le0, b_le0, b_ge0;
  logic [1:0]        quad;
  logic signed [2:0] kx, ky;
  logic signed [W-1:0] dx_next, dy_next;
  hck_axes_t         axes_next;
  logic [KW-1:0]     key_next;

  // levels at or past the configured count pass through untouched
  assign active = {1'b0, level_count} > LEVEL_IDX;

  assign dx_neg = in_dx[W-1];
  assign dy_neg = in_dy[W-1];
  assign dx_pos = !dx_neg && (in_dx != '0);
  assign dy_pos = !dy_neg && (in_dy != '0);

  assign r_le0 = proj_le0(in_axes.rx, in_axes.ry, dx_pos, dx_neg, dy_pos, dy_neg);
  assign b_le0 = proj_le0(in_axes.bx, in_axes.by, dx_pos, dx_neg, dy_pos, dy_neg);
  // b >= 0 is -b <= 0: swap the sign tests
  assign b_ge0 = proj_le0(in_axes.bx, in_axes.by, dx_neg, dx_pos, dy_neg, dy_pos);

  always_comb begin
    axes_next = in_axes;
    if (r_le0 && b_le0) begin
      quad = QUAD_0;
      kx = -(ext3(in_axes.rx) + ext3(in_axes.bx));
      ky = -(ext3(in_axes.ry) + ext3(in_axes.by));
      axes_next = '{rx: in_axes.bx, ry: in_axes.by, bx: in_axes.rx, by: in_axes.ry};
    end else if (r_le0) begin
      quad = QUAD_1;
      kx = ext3(in_axes.bx) - ext3(in_axes.rx);
      ky = ext3(in_axes.by) - ext3(in_axes.ry);
    end else if (b_ge0) begin
      quad = QUAD_2;
      kx = ext3(in_axes.rx) + ext3(in_axes.bx);
      ky = ext3(in_axes.ry) + ext3(in_axes.by);
    end else begin
      quad = QUAD_3;
      kx = ext3(in_axes.rx) - ext3(in_axes.bx);
      ky = ext3(in_axes.ry) - ext3(in_axes.by);
      axes_next = '{rx: -in_axes.bx, ry: -in_axes.by, bx: -in_axes.rx, by: -in_axes.ry};
    end
  end

  // centre moves by kx*h, so the offset moves the other way
  always_comb begin
    if (kx > 3'sd0)      dx_next = in_dx - STEP;
    else if (kx < 3'sd0) dx_next = in_dx + STEP;
    else                 dx_next = in_dx;
    if (ky > 3'sd0)      dy_next = in_dy - STEP;
    else if (ky < 3'sd0) dy_next = in_dy + STEP;
    else                 dy_next = in_dy;
  end

  assign key_next = in_key | (KW'(quad) << KSHIFT);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      out_dx   <= dx_next;
      out_dy   <= dy_next;
      out_axes <= axes_next;
      out_key  <= key_next;
    end else begin
      out_dx   <= in_dx;
      out_dy   <= in_dy;
      out_axes <= in_axes;
      out_key  <= in_key;
    end
  end

endmodule

@@ design/hilbert_curve_key_unit.sv @@
`timescale 1ns / 1ps
// Hilbert curve key of a signed fixed point 2-D point, one level per stage.
// The input register loads at the start edge, and done is raised by the output register
// of the last level stage.
// Throughput: one item per cycle; busy is always low and done cannot be held off.
// Reset clears the stage valid bits and sets level_count to 16.
// Depends on hck_pkg and hck_level.
module hilbert_curve_key_unit #(
  parameter int MAX_DEPTH   = 16,
  parameter int COORD_WIDTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [hck_pkg::LEVEL_COUNT_WIDTH-1:0] cfg_data,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [COORD_WIDTH-1:0]         point_x,
  input  logic signed [COORD_WIDTH-1:0]         point_y,
  output logic                                  done,
  output logic [hck_pkg::KEY_WIDTH-1:0]         hilbert_key
);
  import hck_pkg::*;

  localparam int W  = COORD_WIDTH + MAX_DEPTH + 1;
  localparam int KW = 2 * MAX_DEPTH;

  logic [LEVEL_COUNT_WIDTH-1:0] level_count;

  logic                valid_pipe [0:MAX_DEPTH];
  logic signed [W-1:0] dx_pipe    [0:MAX_DEPTH];
  logic signed [W-1:0] dy_pipe    [0:MAX_DEPTH];
  hck_axes_t           axes_pipe  [0:MAX_DEPTH];
  logic [KW-1:0]       key_pipe   [0:MAX_DEPTH];

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_count <= LEVEL_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      level_count <= cfg_data;
    end
  end

  // input register: offset from the origin, with MAX_DEPTH fraction bits below the LSB
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_pipe[0] <= 1'b0;
    end else begin
      valid_pipe[0] <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    dx_pipe[0]   <= {point_x[COORD_WIDTH-1], point_x, {MAX_DEPTH{1'b0}}};
    dy_pipe[0]   <= {point_y[COORD_WIDTH-1], point_y, {MAX_DEPTH{1'b0}}};
    axes_pipe[0] <= AXES_INIT;
    key_pipe[0]  <= '0;
  end

  for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_level
    hck_level #(
      .COORD_WIDTH (COORD_WIDTH),
      .MAX_DEPTH   (MAX_DEPTH),
      .LEVEL       (i),
      .W           (W),
      .KW          (KW)
    ) u_level (
      .clk         (clk),
      .rst         (rst),
      .level_count (level_count),
      .in_valid    (valid_pipe[i]),
      .in_dx       (dx_pipe[i]),
      .in_dy       (dy_pipe[i]),
      .in_axes     (axes_pipe[i]),
      .in_key      (key_pipe[i]),
      .out_valid   (valid_pipe[i+1]),
      .out_dx      (dx_pipe[i+1]),
      .out_dy      (dy_pipe[i+1]),
      .out_axes    (axes_pipe[i+1]),
      .out_key     (key_pipe[i+1])
    );
  end

  assign done = valid_pipe[MAX_DEPTH];

  // keep the low bits of the left-aligned key, or zero-extend it when narrower than KEY_WIDTH
  if (KW >= KEY_WIDTH) begin : g_key_trunc
    assign hilbert_key = key_pipe[MAX_DEPTH][KEY_WIDTH-1:0];
  end else begin : g_key_ext
    assign hilbert_key = {{(KEY_WIDTH-KW){1'b0}}, key_pipe[MAX_DEPTH]};
  end

endmodule
